// ===== design/button_long_press_toggle_beeper_assert.svh =====
// Assertion macros for the button long-press toggle block.
// Used by modules that have clk and rst_n in scope; no other dependencies.
`ifndef BUTTON_LONG_PRESS_TOGGLE_BEEPER_ASSERT_SVH
`define BUTTON_LONG_PRESS_TOGGLE_BEEPER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BLPTB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BLPTB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/blptb_pkg.sv =====
// Package for the button long-press toggle block: widths, reset values,
// codes and shared types. No dependencies.
package blptb_pkg;

  localparam int COUNT_BITS  = 16;
  localparam int BLINK_COUNT = 3;

  localparam int CFG_W       = 16;
  localparam int PHASE_W     = 8;
  localparam int BEEP_W      = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CMP_W       = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
  localparam int BLINK_PHASES = 2 * BLINK_COUNT;
  localparam int BLINK_BITS  = $clog2(BLINK_PHASES * 255);
  localparam int DIV_CNT_W   = $clog2(BLINK_BITS + 1);

  localparam logic [CFG_W-1:0]   DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_W-1:0]   HOLD_RST     = 16'd3000;
  localparam logic [CFG_W-1:0]   LONG_RST     = 16'd600;
  localparam logic [CFG_W-1:0]   SHORT_RST    = 16'd150;
  localparam logic [PHASE_W-1:0] PHASE_RST    = 8'd60;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 3'd0,
    CFG_HOLD     = 3'd1,
    CFG_LONG     = 3'd2,
    CFG_SHORT    = 3'd3,
    CFG_PHASE    = 3'd4,
    CFG_MUTE     = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    LED_NONE   = 2'd0,
    LED_OFF    = 2'd1,
    LED_ON     = 2'd2,
    LED_TOGGLE = 2'd3
  } led_req_t;

  typedef struct packed {
    logic [CFG_W-1:0]   debounce;
    logic [CFG_W-1:0]   hold;
    logic [CFG_W-1:0]   long_beep;
    logic [CFG_W-1:0]   short_beep;
    logic [PHASE_W-1:0] phase;
    logic               mute;
  } cfg_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [BLINK_BITS-1:0] quo;
    logic [PHASE_W-1:0]    rem;
  } div_res_t;

  // A blink phase of zero behaves as one.
  function automatic logic [PHASE_W-1:0] phase_eff(input logic [PHASE_W-1:0] ph);
    phase_eff = (ph == '0) ? PHASE_W'(1) : ph;
  endfunction

endpackage

// ===== design/blptb_if.sv =====
// Valid/ready channel interfaces for the tick input and the result output.
// Depends on blptb_pkg.
interface blptb_in_if import blptb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              button_down;
  logic [BEEP_W-1:0] beep_request;
  logic [1:0]        led_request;

  modport source(output valid, button_down, beep_request, led_request, input ready);
  modport sink(input valid, button_down, beep_request, led_request, output ready);
endinterface

interface blptb_out_if;
  logic valid;
  logic ready;
  logic buzzer_on;
  logic led_on;
  logic mode_on;
  logic pressed_level;
  logic toggle_event;

  modport source(output valid, buzzer_on, led_on, mode_on, pressed_level, toggle_event,
                 input ready);
  modport sink(input valid, buzzer_on, led_on, mode_on, pressed_level, toggle_event,
               output ready);
endinterface

// ===== design/blptb_cfg.sv =====
// Configuration register file of the button long-press toggle block.
// Depends on blptb_pkg.
module blptb_cfg import blptb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg,
  output logic                 phase_wr
);

  cfg_t cfg_r;
  logic phase_wr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce   <= DEBOUNCE_RST;
      cfg_r.hold       <= HOLD_RST;
      cfg_r.long_beep  <= LONG_RST;
      cfg_r.short_beep <= SHORT_RST;
      cfg_r.phase      <= PHASE_RST;
      cfg_r.mute       <= 1'b0;
      phase_wr_r       <= 1'b0;
    end else begin
      phase_wr_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_DEBOUNCE: cfg_r.debounce   <= cfg_wdata;
          CFG_HOLD:     cfg_r.hold       <= cfg_wdata;
          CFG_LONG:     cfg_r.long_beep  <= cfg_wdata;
          CFG_SHORT:    cfg_r.short_beep <= cfg_wdata;
          CFG_PHASE: begin
            cfg_r.phase <= cfg_wdata[PHASE_W-1:0];
            phase_wr_r  <= 1'b1;
          end
          CFG_MUTE:     cfg_r.mute       <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  assign cfg      = cfg_r;
  assign phase_wr = phase_wr_r;

endmodule

// ===== design/blptb_div.sv =====
// Bit-serial restoring divider that splits the remaining blink count into
// phase number and position after the blink phase length changes. Depends on blptb_pkg.
module blptb_div import blptb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [BLINK_BITS-1:0] num,
  input  logic [PHASE_W-1:0]    divisor,
  output div_res_t              res
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BLINK_BITS-1:0] num_r, num_nxt;
  logic [BLINK_BITS-1:0] quo_r, quo_nxt;
  logic [PHASE_W-1:0]    rem_r, rem_nxt;
  logic [PHASE_W-1:0]    div_r, div_nxt;
  logic [PHASE_W:0]      part;
  logic                  fits;

  always_comb begin
    part     = {rem_r, num_r[BLINK_BITS-1]};
    fits     = part >= {1'b0, div_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(BLINK_BITS);
      num_nxt  = num;
      quo_nxt  = '0;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      num_nxt = {num_r[BLINK_BITS-2:0], 1'b0};
      quo_nxt = {quo_r[BLINK_BITS-2:0], fits};
      rem_nxt = fits ? PHASE_W'(part - {1'b0, div_r}) : part[PHASE_W-1:0];
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign res.busy = busy_r | start | done_r;
  assign res.done = done_r;
  assign res.quo  = quo_r;
  assign res.rem  = rem_r;

endmodule

// ===== design/blptb_core.sv =====
// Per-tick logic: debounce, hold detection, mode toggle, beep and blink timers,
// and the result register. Depends on blptb_pkg, blptb_if and the assertion header.
`include "button_long_press_toggle_beeper_assert.svh"
module blptb_core import blptb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  div_res_t               div_res,
  output logic [BLINK_BITS-1:0]  blink_m1,
  blptb_in_if.sink               in_ch,
  blptb_out_if.source            out_ch
);

  localparam logic [COUNT_BITS-1:0] TSE_MAX = '1;

  logic                  pressed_r, pressed_nxt;
  logic [COUNT_BITS-1:0] tse_r, tse_nxt;
  logic                  hold_done_r, hold_done_nxt;
  logic                  mode_r, mode_nxt;
  logic [BEEP_W-1:0]     beep_r, beep_nxt;
  logic                  blink_act_r, blink_act_nxt;
  logic [BLINK_BITS-1:0] blink_m1_r, blink_m1_nxt;
  logic [BLINK_BITS-1:0] blink_q_r, blink_q_nxt;
  logic [PHASE_W-1:0]    blink_rem_r, blink_rem_nxt;
  logic                  led_r, led_nxt;
  logic                  toggled;

  logic out_valid_r, out_buzzer_r, out_led_r, out_mode_r, out_pressed_r, out_toggle_r;

  logic                  in_fire;
  logic [PHASE_W-1:0]    ph;

  assign ph       = phase_eff(cfg.phase);
  assign in_ch.ready = !div_res.busy && (!out_valid_r || out_ch.ready);
  assign in_fire  = in_ch.valid && in_ch.ready;

  always_comb begin
    tse_nxt       = (tse_r != TSE_MAX) ? tse_r + COUNT_BITS'(1) : tse_r;
    beep_nxt      = (beep_r != '0) ? beep_r - BEEP_W'(1) : beep_r;
    pressed_nxt   = pressed_r;
    hold_done_nxt = hold_done_r;
    mode_nxt      = mode_r;
    led_nxt       = led_r;
    toggled       = 1'b0;

    blink_act_nxt = blink_act_r;
    blink_m1_nxt  = blink_m1_r;
    blink_q_nxt   = blink_q_r;
    blink_rem_nxt = blink_rem_r;
    if (blink_act_r) begin
      if (blink_m1_r == '0) begin
        blink_act_nxt = 1'b0;
      end else begin
        blink_m1_nxt = blink_m1_r - BLINK_BITS'(1);
        if (blink_rem_r == '0) begin
          blink_q_nxt   = blink_q_r - BLINK_BITS'(1);
          blink_rem_nxt = ph - PHASE_W'(1);
        end else begin
          blink_rem_nxt = blink_rem_r - PHASE_W'(1);
        end
      end
    end

    if (in_ch.button_down != pressed_r && CMP_W'(tse_nxt) >= CMP_W'(cfg.debounce)) begin
      pressed_nxt = in_ch.button_down;
      tse_nxt     = '0;
      if (!in_ch.button_down) begin
        hold_done_nxt = 1'b0;
      end
    end

    if (pressed_nxt && !hold_done_nxt && CMP_W'(tse_nxt) >= CMP_W'(cfg.hold)) begin
      hold_done_nxt = 1'b1;
      mode_nxt      = !mode_r;
      toggled       = 1'b1;
    end

    if (in_ch.beep_request != '0 && !cfg.mute) begin
      beep_nxt = in_ch.beep_request;
    end
    if (toggled) begin
      if (!cfg.mute) begin
        beep_nxt = mode_nxt ? cfg.long_beep : cfg.short_beep;
      end
      blink_act_nxt = 1'b1;
      blink_m1_nxt  = BLINK_BITS'(BLINK_PHASES) * BLINK_BITS'(ph) - BLINK_BITS'(1);
      blink_q_nxt   = BLINK_BITS'(BLINK_PHASES - 1);
      blink_rem_nxt = ph - PHASE_W'(1);
    end

    if (blink_act_nxt) begin
      led_nxt = blink_q_nxt[0];
    end else begin
      unique case (led_req_t'(in_ch.led_request))
        LED_NONE:   led_nxt = led_r;
        LED_OFF:    led_nxt = 1'b0;
        LED_ON:     led_nxt = 1'b1;
        LED_TOGGLE: led_nxt = !led_r;
        default:    led_nxt = led_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r   <= 1'b0;
      tse_r       <= TSE_MAX;
      hold_done_r <= 1'b0;
      mode_r      <= 1'b0;
      beep_r      <= '0;
      blink_act_r <= 1'b0;
      led_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        pressed_r   <= pressed_nxt;
        tse_r       <= tse_nxt;
        hold_done_r <= hold_done_nxt;
        mode_r      <= mode_nxt;
        beep_r      <= beep_nxt;
        blink_act_r <= blink_act_nxt;
        led_r       <= led_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      blink_m1_r    <= blink_m1_nxt;
      blink_q_r     <= blink_q_nxt;
      blink_rem_r   <= blink_rem_nxt;
      out_buzzer_r  <= beep_nxt != '0;
      out_led_r     <= led_nxt;
      out_mode_r    <= mode_nxt;
      out_pressed_r <= pressed_nxt;
      out_toggle_r  <= toggled;
    end else if (div_res.done) begin
      blink_q_r   <= div_res.quo;
      blink_rem_r <= div_res.rem;
    end
  end

  assign blink_m1             = blink_m1_r;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.buzzer_on     = out_buzzer_r;
  assign out_ch.led_on        = out_led_r;
  assign out_ch.mode_on       = out_mode_r;
  assign out_ch.pressed_level = out_pressed_r;
  assign out_ch.toggle_event  = out_toggle_r;

  `BLPTB_ASSERT_IMP(a_no_item_while_dividing, in_fire, !div_res.busy, "item taken during divide")
  `BLPTB_ASSERT_NXT(a_toggle_starts_blink, in_fire && toggled,
                    blink_act_r && out_valid_r && out_toggle_r, "toggle did not start blink")
  `BLPTB_ASSERT_NXT(a_toggle_flips_mode, in_fire && toggled,
                    out_mode_r != $past(mode_r), "toggle did not flip mode")
  `BLPTB_ASSERT_IMP(a_blink_pos_in_phase, blink_act_r && !div_res.busy,
                    blink_rem_r < ph, "blink position beyond phase length")

endmodule

// ===== design/button_long_press_toggle_beeper.sv =====
// Top level of the button long-press toggle block with beeper and LED blink.
// Depends on blptb_pkg, blptb_if, blptb_cfg, blptb_div and blptb_core.
//
// Usage: each input item on in_ch is one millisecond tick with the raw button
// level, an optional beep length and an optional LED command. Each tick gives
// exactly one result item on out_ch with buzzer, LED, mode, debounced button
// and toggle-event levels.
// out_ch.valid rises in the cycle after acceptance. A new item can be accepted
// every cycle while results are taken and no divide runs; the result register
// lets the next item in while the current result is taken in the same cycle.
// When out_ch.ready is low and a result is waiting, in_ch.ready drops and the
// state holds until the result is taken.
// A write to the blink phase register starts a bit-serial divider that
// re-splits a running blink; in_ch.ready is low while the divider runs and
// until its done pulse has loaded the result into the blink counters.
// Registers are to be written through cfg_we, cfg_index and cfg_wdata while idle; the block does not enforce this.
// Synchronous active-low reset restores register defaults, clears the mode,
// timers and LED, and marks the button counter as long settled.
module button_long_press_toggle_beeper import blptb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  blptb_in_if.sink             in_ch,
  blptb_out_if.source          out_ch
);

  cfg_t                  cfg;
  logic                  phase_wr;
  div_res_t              div_res;
  logic [BLINK_BITS-1:0] blink_m1;

  blptb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .phase_wr  (phase_wr)
  );

  blptb_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (phase_wr),
    .num     (blink_m1),
    .divisor (phase_eff(cfg.phase)),
    .res     (div_res)
  );

  blptb_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .div_res  (div_res),
    .blink_m1 (blink_m1),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

endmodule

// ===== tb/blptb_tick_checker.sv =====
// Result checker for the button long-press toggle block: it follows the register
// writes, predicts one result item per accepted tick and compares it with the output.
// Depends on blptb_pkg and the channel interfaces in blptb_if.
module blptb_tick_checker
  import blptb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  blptb_in_if                  tick_ch,
  blptb_out_if                 res_ch,
  output int                   mismatches,
  output int                   results_due,
  output int                   results_checked,
  output int                   toggles_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic buzzer;
    logic led;
    logic mode;
    logic pressed;
    logic toggled;
  } tick_res_t;

  cfg_t                  regs;
  logic                  pressed_q;
  logic                  hold_latched;
  logic                  mode_q;
  logic                  led_q;
  logic [COUNT_BITS-1:0] since_edge;
  logic [BEEP_W-1:0]     beep_cnt;
  logic [BLINK_BITS-1:0] blink_cnt;
  tick_res_t             due_q[$];

  task automatic reset_model();
    regs.debounce   = DEBOUNCE_RST;
    regs.hold       = HOLD_RST;
    regs.long_beep  = LONG_RST;
    regs.short_beep = SHORT_RST;
    regs.phase      = PHASE_RST;
    regs.mute       = 1'b0;
    pressed_q       = 1'b0;
    hold_latched    = 1'b0;
    mode_q          = 1'b0;
    led_q           = 1'b0;
    since_edge      = '1;
    beep_cnt        = '0;
    blink_cnt       = '0;
  endtask

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    case (idx)
      CFG_DEBOUNCE: regs.debounce = data;
      CFG_HOLD:     regs.hold = data;
      CFG_LONG:     regs.long_beep = data;
      CFG_SHORT:    regs.short_beep = data;
      CFG_PHASE:    regs.phase = data[PHASE_W-1:0];
      CFG_MUTE:     regs.mute = data[0];
      default:      ;
    endcase
  endtask

  task automatic advance_tick(input logic down, input logic [BEEP_W-1:0] req,
                              input led_req_t led_cmd, output tick_res_t r);
    logic [PHASE_W-1:0] ph;
    logic               flip;
    int                 step;
    ph = (regs.phase == '0) ? PHASE_W'(1) : regs.phase;
    flip = 1'b0;
    if (since_edge != '1) since_edge = since_edge + 1'b1;
    if (beep_cnt != '0) beep_cnt = beep_cnt - 1'b1;
    if (blink_cnt != '0) blink_cnt = blink_cnt - 1'b1;

    if (down != pressed_q && since_edge >= regs.debounce) begin
      pressed_q = down;
      since_edge = '0;
      if (!pressed_q) hold_latched = 1'b0;
    end

    if (pressed_q && !hold_latched && since_edge >= regs.hold) begin
      hold_latched = 1'b1;
      mode_q = ~mode_q;
      flip = 1'b1;
    end

    if (req != '0 && !regs.mute) beep_cnt = req;
    if (flip) begin
      if (!regs.mute) beep_cnt = mode_q ? regs.long_beep : regs.short_beep;
      blink_cnt = BLINK_BITS'(BLINK_PHASES * int'(ph));
    end

    if (blink_cnt != '0) begin
      step = (int'(blink_cnt) - 1) / int'(ph);
      led_q = step[0];
    end else begin
      case (led_cmd)
        LED_OFF:    led_q = 1'b0;
        LED_ON:     led_q = 1'b1;
        LED_TOGGLE: led_q = ~led_q;
        default:    ;
      endcase
    end

    r.buzzer  = (beep_cnt != '0);
    r.led     = led_q;
    r.mode    = mode_q;
    r.pressed = pressed_q;
    r.toggled = flip;
  endtask

  task automatic compare_bit(input string field, input logic want, input logic got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0b, got %0b", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    tick_res_t want;
    tick_res_t got;
    if (!rst_n) begin
      reset_model();
      due_q.delete();
      mismatches      = 0;
      results_checked = 0;
      toggles_seen    = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got.buzzer  = res_ch.buzzer_on;
        got.led     = res_ch.led_on;
        got.mode    = res_ch.mode_on;
        got.pressed = res_ch.pressed_level;
        got.toggled = res_ch.toggle_event;
        if (due_q.size() == 0) begin
          mismatches++;
          $display("%0t: result item with none expected, got %b", $time, got);
        end else begin
          want = due_q.pop_front();
          compare_bit("buzzer_on", want.buzzer, got.buzzer);
          compare_bit("led_on", want.led, got.led);
          compare_bit("mode_on", want.mode, got.mode);
          compare_bit("pressed_level", want.pressed, got.pressed);
          compare_bit("toggle_event", want.toggled, got.toggled);
          results_checked++;
          if (want.toggled) toggles_seen++;
        end
      end
      if (tick_ch.valid && tick_ch.ready) begin
        advance_tick(tick_ch.button_down, tick_ch.beep_request,
                     led_req_t'(tick_ch.led_request), want);
        due_q.push_back(want);
      end
      if (cfg_we) apply_write(cfg_index, cfg_wdata);
    end
    results_due = due_q.size();
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the button long-press toggle block: clock, reset, register
// writes, directed and random ticks with random stalls, and the verdict.
// Depends on blptb_pkg, blptb_if, the block itself and blptb_tick_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import blptb_pkg::*;

  localparam int RESET_CYCLES    = 11;
  localparam int NUM_PHASES      = 7;
  localparam int TICKS_PER_PHASE = 75;
  localparam int HOLD_OFF_CYCLES = 48;
  localparam int WATCHDOG_LIMIT  = 500;
  localparam int DRAIN_CYCLES    = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int   mismatches;
  int   results_due;
  int   results_checked;
  int   toggles_seen;
  int   gap_odds;
  int   hold_off_asked;
  int   settings_used;
  int   quiet_cycles;
  int   run_max;
  int   run_left;
  logic btn_level;

  blptb_in_if  tick_ch();
  blptb_out_if res_ch();

  button_long_press_toggle_beeper DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (tick_ch),
    .out_ch    (res_ch)
  );

  blptb_tick_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .tick_ch         (tick_ch),
    .res_ch          (res_ch),
    .mismatches      (mismatches),
    .results_due     (results_due),
    .results_checked (results_checked),
    .toggles_seen    (toggles_seen)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no item moved for %0d cycles", $time, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_sink
    int served;
    served = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_asked > served) begin
        served++;
        res_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_tick(input logic down, input logic [BEEP_W-1:0] req,
                           input led_req_t led_cmd);
    @(negedge clk);
    tick_ch.valid        <= 1'b1;
    tick_ch.button_down  <= down;
    tick_ch.beep_request <= req;
    tick_ch.led_request  <= led_cmd;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
  endtask

  task automatic pace_sender();
    if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      @(negedge clk);
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end
  endtask

  task automatic random_tick();
    logic              down;
    logic [BEEP_W-1:0] req;
    led_req_t          led_cmd;
    if (run_left == 0) begin
      btn_level = ~btn_level;
      run_left = $urandom_range(1, run_max);
    end
    run_left--;
    down = btn_level;
    if ($urandom_range(0, 15) == 0) down = ~down;
    case ($urandom_range(0, 15))
      0:       req = BEEP_W'($urandom());
      1, 2:    req = BEEP_W'($urandom_range(1, 40));
      default: req = '0;
    endcase
    led_cmd = ($urandom_range(0, 1) == 0) ? LED_NONE : led_req_t'($urandom_range(0, 3));
    pace_sender();
    send_tick(down, req, led_cmd);
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    tick_ch.valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic program_regs(input cfg_t c);
    write_reg(CFG_DEBOUNCE, c.debounce);
    write_reg(CFG_HOLD, c.hold);
    write_reg(CFG_LONG, c.long_beep);
    write_reg(CFG_SHORT, c.short_beep);
    write_reg(CFG_PHASE, CFG_W'(c.phase));
    write_reg(CFG_MUTE, CFG_W'(c.mute));
    end_writes();
  endtask

  task automatic choose_setting(input int p, output cfg_t c);
    c.debounce   = CFG_W'($urandom_range(0, 6));
    c.hold       = CFG_W'($urandom_range(0, 24));
    c.long_beep  = CFG_W'($urandom_range(1, 40));
    c.short_beep = CFG_W'($urandom_range(1, 20));
    c.phase      = PHASE_W'($urandom_range(0, 4));
    c.mute       = ($urandom_range(0, 3) == 0);
    case (p)
      1: begin
        c.debounce   = '1;
        c.hold       = '1;
        c.long_beep  = '1;
        c.short_beep = '1;
        c.phase      = '1;
        c.mute       = 1'b1;
      end
      2: begin
        c.debounce   = CFG_W'(1);
        c.hold       = CFG_W'(1);
        c.long_beep  = CFG_W'(1);
        c.short_beep = CFG_W'(1);
        c.phase      = PHASE_W'(1);
        c.mute       = 1'b0;
      end
      4: begin
        c.debounce  = CFG_W'(1);
        c.hold      = CFG_W'(3);
        c.long_beep = '1;
        c.phase     = '1;
        c.mute      = 1'b0;
      end
      default: ;
    endcase
  endtask

  initial begin : stimulus
    cfg_t setting;
    int   span;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = CFG_DEBOUNCE;
    cfg_wdata            = '0;
    tick_ch.valid        = 1'b0;
    tick_ch.button_down  = 1'b0;
    tick_ch.beep_request = '0;
    tick_ch.led_request  = LED_NONE;
    gap_odds             = 4;
    hold_off_asked       = 0;
    settings_used        = 1;
    quiet_cycles         = 0;
    btn_level            = 1'b0;
    run_left             = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: the first press passes at once, a quick release is filtered.
    send_tick(1'b0, '0, LED_NONE);
    send_tick(1'b1, BEEP_W'(1), LED_ON);
    send_tick(1'b1, '0, LED_TOGGLE);
    send_tick(1'b0, '1, LED_OFF);
    send_tick(1'b0, BEEP_W'(16'h5AA5), LED_TOGGLE);
    run_max = 20;
    repeat (30) random_tick();

    // Zero debounce, zero hold and a zero blink phase written with junk above its width.
    wait_quiet();
    write_reg(CFG_DEBOUNCE, '0);
    write_reg(CFG_HOLD, '0);
    write_reg(CFG_LONG, CFG_W'(1));
    write_reg(CFG_SHORT, '1);
    write_reg(CFG_PHASE, 16'hA500);
    write_reg(CFG_MUTE, 16'h0002);
    end_writes();
    send_tick(1'b1, '0, LED_ON);
    send_tick(1'b1, '0, LED_OFF);
    send_tick(1'b0, '0, LED_NONE);
    send_tick(1'b1, '0, LED_TOGGLE);
    repeat (6) send_tick(1'b1, '0, LED_TOGGLE);

    // Muting leaves the running beep alone and blocks new ones.
    wait_quiet();
    write_reg(CFG_MUTE, 16'h0001);
    end_writes();
    send_tick(1'b0, BEEP_W'(7), LED_NONE);
    send_tick(1'b1, '0, LED_NONE);
    send_tick(1'b1, BEEP_W'(3), LED_ON);
    send_tick(1'b1, '0, LED_TOGGLE);
    wait_quiet();
    write_reg(CFG_MUTE, 16'hFFFE);
    write_reg(CFG_SPARE, '1);
    write_reg(CFG_SPARE_HI, '0);
    end_writes();
    send_tick(1'b0, BEEP_W'(2), LED_OFF);
    send_tick(1'b0, '0, LED_NONE);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_quiet();
      choose_setting(p, setting);
      program_regs(setting);
      gap_odds = (p == 3 || p == NUM_PHASES - 1) ? 0 : 5;
      span = int'(setting.hold) + 2 * int'(setting.debounce) + 12;
      run_max = (span > 80) ? 80 : span;
      run_left = 0;
      for (int i = 0; i < TICKS_PER_PHASE; i++) begin
        if (p == 2 && i == 20) hold_off_asked++;
        random_tick();
      end
    end

    wait_quiet();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Checked %0d result items under %0d register settings; the mode toggled %0d times.",
             results_checked, settings_used, toggles_seen);
    $display("Covered zero and full-scale registers, muting, restarted blinks and output stalls.");
    if (mismatches == 0 && results_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
